### rtl/core/rbei_pkg.sv
// ============================================================================
// rbei_pkg - shared types and helpers of the rigid body Euler integrator
// Opcodes, controller states, datapath command and status records, and the
// saturation helpers used by the datapath.
// ============================================================================
package rbei_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DT_BITS       = 16;
    localparam int WORD_W        = 32;
    localparam int INV_W         = 31;
    localparam int OPCODE_W      = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int IN_TDATA_W    = 88;
    localparam int OUT_TDATA_W   = 200;

    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_MASS    = 4'd0,
        REG_INV_INERTIA = 4'd1
    } t_cfg_reg;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_FORCE  = 3'd0,
        OP_ADD_TORQUE = 3'd1,
        OP_SET_VEL    = 3'd2,
        OP_SET_SPIN   = 3'd3,
        OP_TRANSLATE  = 3'd4,
        OP_UPDATE     = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULT,
        ST_DONE
    } t_state;

    // What one pass through the shared multiplier computes.
    typedef enum logic [1:0] {
        K_VEL_DT,   // velocity times dt, added into position
        K_ACCEL,    // force sum times inverse, clipped into acceleration
        K_ACC_DT    // acceleration times dt, added into velocity
    } t_kind;

    // Which component: x, y, or the rotational one.
    typedef enum logic [1:0] {
        LANE_X,
        LANE_Y,
        LANE_ROT
    } t_lane;

    typedef struct packed {
        logic  latch;
        logic  exec;
        logic  issue;
        t_kind iss_kind;
        t_lane iss_lane;
        logic  consume;
        t_kind con_kind;
        t_lane con_lane;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic is_update;
    } t_status;

    typedef struct packed {
        logic                     clip;
        logic signed [WORD_W-1:0] val;
    } t_sat;

    // Clips a wide signed value to 32 bit signed and flags the clip.
    function automatic t_sat sat_wide(input logic signed [64:0] v);
        t_sat r;
        if (v > 65'sd2147483647) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // Saturating add of two 32 bit signed values.
    function automatic t_sat add_sat(input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return sat_wide({{(64-WORD_W){s[WORD_W]}}, s});
    endfunction

    function automatic logic signed [WORD_W-1:0] sel3(input t_lane l,
                                                      input logic signed [WORD_W-1:0] a,
                                                      input logic signed [WORD_W-1:0] b,
                                                      input logic signed [WORD_W-1:0] c);
        logic signed [WORD_W-1:0] r;
        case (l)
            LANE_X:  r = a;
            LANE_Y:  r = b;
            LANE_ROT: r = c;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/rbei_ctrl.sv
// ============================================================================
// rbei_ctrl - sequencer of the rigid body Euler integrator
// Takes requests, steps the datapath through the multiplier passes of an
// update, and hands finished results to the output register.
// ============================================================================
module rbei_ctrl
    import rbei_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    t_lane  r_lane, n_lane;
    logic   r_busy, n_busy;
    logic   r_cvalid, n_cvalid;
    t_kind  r_ckind, n_ckind;
    t_lane  r_clane, n_clane;
    logic   r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kind    <= K_VEL_DT;
            r_lane    <= LANE_X;
            r_busy    <= 1'b0;
            r_cvalid  <= 1'b0;
            r_ckind   <= K_VEL_DT;
            r_clane   <= LANE_X;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_lane    <= n_lane;
            r_busy    <= n_busy;
            r_cvalid  <= n_cvalid;
            r_ckind   <= n_ckind;
            r_clane   <= n_clane;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_lane    = r_lane;
        n_busy    = r_busy;
        n_cvalid  = 1'b0;
        n_ckind   = r_kind;
        n_clane   = r_lane;
        n_m_valid = r_m_valid && !i_m_tready;
        o_s_tready = 1'b0;
        o_cmd          = '0;
        o_cmd.iss_kind = r_kind;
        o_cmd.iss_lane = r_lane;
        o_cmd.con_kind = r_ckind;
        o_cmd.con_lane = r_clane;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_update) begin
                    n_state = ST_MULT;
                    n_kind  = K_VEL_DT;
                    n_lane  = LANE_X;
                    n_busy  = 1'b1;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_MULT: begin
                // A product issued in one cycle is consumed in the next.
                o_cmd.issue   = r_busy;
                o_cmd.consume = r_cvalid;
                n_cvalid      = r_busy;
                if (r_busy) begin
                    case (r_lane)
                        LANE_X:  n_lane = LANE_Y;
                        LANE_Y:  n_lane = LANE_ROT;
                        default: begin
                            n_lane = LANE_X;
                            case (r_kind)
                                K_VEL_DT: n_kind = K_ACCEL;
                                K_ACCEL:  n_kind = K_ACC_DT;
                                default:  n_busy = 1'b0;
                            endcase
                        end
                    endcase
                end else if (r_cvalid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_tvalid = r_m_valid;

endmodule

### rtl/core/rbei_dp.sv
// ============================================================================
// rbei_dp - datapath of the rigid body Euler integrator
// Body state, inverse mass and inertia registers, one shared signed
// multiplier with a registered product, saturating adds and the result
// register.
// ============================================================================
module rbei_dp
    import rbei_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic signed [WORD_W-1:0]   i_operand_x,
    input  logic signed [WORD_W-1:0]   i_operand_y,
    input  logic [DT_BITS-1:0]         i_time_step,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [WORD_W-1:0]          i_cfg_data,
    output logic signed [WORD_W-1:0]   o_pos_x,
    output logic signed [WORD_W-1:0]   o_pos_y,
    output logic signed [WORD_W-1:0]   o_vel_x,
    output logic signed [WORD_W-1:0]   o_vel_y,
    output logic signed [WORD_W-1:0]   o_angle,
    output logic signed [WORD_W-1:0]   o_spin_rate,
    output logic                       o_saturated
);

    logic [INV_W-1:0]         r_inv_mass, r_inv_inertia;
    logic [OPCODE_W-1:0]      r_op;
    logic signed [WORD_W-1:0] r_ox, r_oy;
    logic [DT_BITS-1:0]       r_dt;
    logic signed [WORD_W-1:0] r_pos_x, r_pos_y, r_rot;
    logic signed [WORD_W-1:0] r_vel_x, r_vel_y, r_spin;
    logic signed [WORD_W-1:0] r_frc_x, r_frc_y, r_torque;
    logic signed [WORD_W-1:0] r_acc_x, r_acc_y, r_acc_rot;
    logic                     r_sat;
    logic signed [63:0]       r_prod;
    logic signed [WORD_W-1:0] r_o_pos_x, r_o_pos_y, r_o_vel_x, r_o_vel_y;
    logic signed [WORD_W-1:0] r_o_angle, r_o_spin;
    logic                     r_o_sat;

    logic signed [WORD_W-1:0] w_mul_a;
    logic signed [WORD_W:0]   w_mul_b;
    logic signed [64:0]       w_prod;
    logic signed [63:0]       w_shift;
    logic signed [WORD_W-1:0] w_base, w_ex_base0, w_ex_base1;
    t_sat                     w_acc, w_csum, w_ex0, w_ex1;

    // Shared multiplier: a signed state value times an unsigned dt or inverse.
    always_comb begin
        case (i_cmd.iss_kind)
            K_VEL_DT: w_mul_a = sel3(i_cmd.iss_lane, r_vel_x, r_vel_y, r_spin);
            K_ACCEL:  w_mul_a = sel3(i_cmd.iss_lane, r_frc_x, r_frc_y, r_torque);
            K_ACC_DT: w_mul_a = sel3(i_cmd.iss_lane, r_acc_x, r_acc_y, r_acc_rot);
            default:  w_mul_a = '0;
        endcase
        if (i_cmd.iss_kind == K_ACCEL) begin
            w_mul_b = (i_cmd.iss_lane == LANE_ROT) ? {2'b00, r_inv_inertia}
                                                   : {2'b00, r_inv_mass};
        end else begin
            w_mul_b = {{(WORD_W + 1 - DT_BITS){1'b0}}, r_dt};
        end
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Consume the registered product: floor shift, then clip or accumulate.
    always_comb begin
        w_shift = (i_cmd.con_kind == K_ACCEL) ? (r_prod >>> FRAC_BITS)
                                              : (r_prod >>> DT_BITS);
        w_acc   = sat_wide({w_shift[63], w_shift});
        w_base  = (i_cmd.con_kind == K_VEL_DT)
                ? sel3(i_cmd.con_lane, r_pos_x, r_pos_y, r_rot)
                : sel3(i_cmd.con_lane, r_vel_x, r_vel_y, r_spin);
        w_csum  = add_sat(w_base, w_shift[WORD_W-1:0]);
    end

    // Single-step operations.
    always_comb begin
        case (r_op)
            OP_ADD_FORCE:  w_ex_base0 = r_frc_x;
            OP_ADD_TORQUE: w_ex_base0 = r_torque;
            default:       w_ex_base0 = r_pos_x;
        endcase
        w_ex_base1 = (r_op == OP_ADD_FORCE) ? r_frc_y : r_pos_y;
        w_ex0 = add_sat(w_ex_base0, r_ox);
        w_ex1 = add_sat(w_ex_base1, r_oy);
    end

    assign o_status.is_update = (r_op == OP_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= INV_RESET;
            r_inv_inertia <= INV_RESET;
            r_op      <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_rot     <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_spin    <= '0;
            r_frc_x   <= '0;
            r_frc_y   <= '0;
            r_torque  <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_acc_rot <= '0;
            r_sat     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INV_MASS:    r_inv_mass    <= i_cfg_data[INV_W-1:0];
                    REG_INV_INERTIA: r_inv_inertia <= i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_op  <= i_opcode;
                r_sat <= 1'b0;
            end

            if (i_cmd.exec) begin
                case (r_op)
                    OP_ADD_FORCE: begin
                        r_frc_x <= w_ex0.val;
                        r_frc_y <= w_ex1.val;
                        r_sat   <= w_ex0.clip | w_ex1.clip;
                    end
                    OP_ADD_TORQUE: begin
                        r_torque <= w_ex0.val;
                        r_sat    <= w_ex0.clip;
                    end
                    OP_SET_VEL: begin
                        r_vel_x <= r_ox;
                        r_vel_y <= r_oy;
                    end
                    OP_SET_SPIN: r_spin <= r_ox;
                    OP_TRANSLATE: begin
                        r_pos_x <= w_ex0.val;
                        r_pos_y <= w_ex1.val;
                        r_sat   <= w_ex0.clip | w_ex1.clip;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.consume) begin
                case (i_cmd.con_kind)
                    K_VEL_DT: begin
                        r_sat <= r_sat | w_csum.clip;
                        case (i_cmd.con_lane)
                            LANE_X:  r_pos_x <= w_csum.val;
                            LANE_Y:  r_pos_y <= w_csum.val;
                            default: r_rot   <= w_csum.val;
                        endcase
                    end
                    K_ACCEL: begin
                        r_sat <= r_sat | w_acc.clip;
                        case (i_cmd.con_lane)
                            LANE_X:  r_acc_x   <= w_acc.val;
                            LANE_Y:  r_acc_y   <= w_acc.val;
                            default: r_acc_rot <= w_acc.val;
                        endcase
                    end
                    default: begin
                        r_sat <= r_sat | w_csum.clip;
                        case (i_cmd.con_lane)
                            LANE_X:  r_vel_x <= w_csum.val;
                            LANE_Y:  r_vel_y <= w_csum.val;
                            default: r_spin  <= w_csum.val;
                        endcase
                    end
                endcase
            end
        end
    end

    // Operands, product and result words carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ox <= i_operand_x;
            r_oy <= i_operand_y;
            r_dt <= i_time_step;
        end
        if (i_cmd.issue) begin
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.load_out) begin
            r_o_pos_x <= r_pos_x;
            r_o_pos_y <= r_pos_y;
            r_o_vel_x <= r_vel_x;
            r_o_vel_y <= r_vel_y;
            r_o_angle <= r_rot;
            r_o_spin  <= r_spin;
            r_o_sat   <= r_sat;
        end
    end

    assign o_pos_x     = r_o_pos_x;
    assign o_pos_y     = r_o_pos_y;
    assign o_vel_x     = r_o_vel_x;
    assign o_vel_y     = r_o_vel_y;
    assign o_angle     = r_o_angle;
    assign o_spin_rate = r_o_spin;
    assign o_saturated = r_o_sat;

endmodule

### rtl/core/rigid_body_euler_integrator.sv
// ============================================================================
// rigid_body_euler_integrator - explicit Euler state of one 2D rigid body
// Top level: stream ports, configuration port, sequencer and datapath.
// ============================================================================
// The block holds position, velocity, angle, angular velocity and running
// force and torque sums of one body in signed fixed point with FRAC_BITS
// fraction bits. Every request carries an opcode and returns exactly one
// result with the full body state after the request and a flag that is set
// when any value was clipped to 32 bit signed. The block works on one
// request at a time. Add force, add torque, set velocity, set angular
// velocity and translate are applied in a single execute state before the
// result register is loaded. An update makes nine passes through one shared
// signed 32 by 33 bit multiplier, one product per cycle, each registered and
// consumed in the following cycle. A new request is taken as soon as the
// previous one has reached the result register, even while that result
// still waits downstream. Opcodes six and seven change nothing.
// Inverse mass and inverse inertia are written through the configuration
// port, which is always ready; write them only while no request is in work.
// ============================================================================
module rigid_body_euler_integrator
    import rbei_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // From bit 0: opcode[3], operand_x[32], operand_y[32], time_step[16], zero pad.
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Result stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // From bit 0: pos_x, pos_y, vel_x, vel_y, angle, spin_rate (32 each),
    // saturated[1], zero pad.
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // Configuration writes: index 0 inverse mass, index 1 inverse inertia.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data
);

    t_cmd                     w_cmd;
    t_status                  w_status;
    logic signed [WORD_W-1:0] w_pos_x, w_pos_y, w_vel_x, w_vel_y;
    logic signed [WORD_W-1:0] w_angle, w_spin;
    logic                     w_saturated;

    assign o_cfg_ready = 1'b1;

    rbei_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbei_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_opcode    (i_s_tdata[2:0]),
        .i_operand_x (i_s_tdata[34:3]),
        .i_operand_y (i_s_tdata[66:35]),
        .i_time_step (i_s_tdata[82:67]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pos_x     (w_pos_x),
        .o_pos_y     (w_pos_y),
        .o_vel_x     (w_vel_x),
        .o_vel_y     (w_vel_y),
        .o_angle     (w_angle),
        .o_spin_rate (w_spin),
        .o_saturated (w_saturated)
    );

    assign o_m_tdata = {7'b0, w_saturated, w_spin, w_angle,
                        w_vel_y, w_vel_x, w_pos_y, w_pos_x};

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // A result appears only at the end of a request in work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result raised without a request in work");

endmodule

### sim/rigid_body_euler_integrator_tb.sv
// ============================================================================
// rigid_body_euler_integrator_tb - self-checking bench for the Euler integrator
// Drives opcode requests into the body integrator, predicts the body state
// after every request in fixed point and compares each returned result field
// by field. Directed extremes come first. Randomized traffic follows under
// several inverse mass and inertia settings, with random stalls on both
// streams and one long output hold-off.
// ============================================================================
module rigid_body_euler_integrator_tb
    import rbei_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = DEF_FRAC_BITS;

    // Opcodes that the block must treat as no operation.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 4'd15;

    localparam logic signed [WORD_W-1:0] WORD_POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [WORD_W-1:0] WORD_NEG_MAX = 32'sh80000000;
    localparam logic [WORD_W-1:0]        INV_MAX      = 32'h7FFFFFFF;
    localparam logic [15:0]              DT_MAX       = 16'hFFFF;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    localparam int MAX_PRINTED = 40;

    // ------------------------------------------------------------------------
    // Block connections. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [WORD_W-1:0]      i_cfg_data  = '0;

    rigid_body_euler_integrator #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Body state as the bench expects it, one entry per outstanding request.
    // ------------------------------------------------------------------------
    typedef struct {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] angle;
        logic signed [WORD_W-1:0] spin_rate;
        logic                     saturated;
    } t_body_state;

    t_body_state expected_states[$];

    // Shadow copy of the body and of the two inverse registers.
    logic signed [WORD_W-1:0] body_pos[2];
    logic signed [WORD_W-1:0] body_vel[2];
    logic signed [WORD_W-1:0] body_angle;
    logic signed [WORD_W-1:0] body_spin;
    logic signed [WORD_W-1:0] force_total[2];
    logic signed [WORD_W-1:0] torque_total;
    logic [INV_W-1:0]         shadow_inv_mass    = INV_RESET;
    logic [INV_W-1:0]         shadow_inv_inertia = INV_RESET;
    bit                       clip_seen;

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int updates_sent    = 0;
    int results_checked = 0;
    int register_writes = 0;

    // Idling controls shared by the stimulus and the output ready process.
    bit tx_idle_on       = 1'b1;
    bit rx_idle_on       = 1'b1;
    int hold_cycles_left = 0;

    initial begin
        body_pos[0]    = '0;
        body_pos[1]    = '0;
        body_vel[0]    = '0;
        body_vel[1]    = '0;
        body_angle     = '0;
        body_spin      = '0;
        force_total[0] = '0;
        force_total[1] = '0;
        torque_total   = '0;
    end

    // Clips a wide value to 32 bit signed and remembers that it clipped.
    function automatic logic signed [WORD_W-1:0] clip_word(input longint v);
        if (v > SAT_HI) begin
            clip_seen = 1'b1;
            return WORD_POS_MAX;
        end
        if (v < SAT_LO) begin
            clip_seen = 1'b1;
            return WORD_NEG_MAX;
        end
        return v[WORD_W-1:0];
    endfunction

    // Value times a Q0.16 step; the arithmetic shift rounds toward minus infinity.
    function automatic longint scale_by_step(input longint value, input logic [15:0] dt);
        return (value * longint'({48'd0, dt})) >>> DT_BITS;
    endfunction

    // Force or torque total times an inverse, clipped before it meets the step.
    function automatic logic signed [WORD_W-1:0] accel_of(input longint total,
                                                          input logic [INV_W-1:0] inv);
        return clip_word((total * longint'({33'd0, inv})) >>> FRAC);
    endfunction

    // Applies one request to the shadow body and returns the state it leaves.
    function automatic t_body_state advance_body(input logic [OPCODE_W-1:0] op,
                                                 input logic signed [WORD_W-1:0] ox,
                                                 input logic signed [WORD_W-1:0] oy,
                                                 input logic [15:0] dt);
        t_body_state              s;
        logic signed [WORD_W-1:0] acc;
        clip_seen = 1'b0;
        case (op)
            OP_ADD_FORCE: begin
                force_total[0] = clip_word(longint'(force_total[0]) + ox);
                force_total[1] = clip_word(longint'(force_total[1]) + oy);
            end
            OP_ADD_TORQUE: begin
                torque_total = clip_word(longint'(torque_total) + ox);
            end
            OP_SET_VEL: begin
                body_vel[0] = ox;
                body_vel[1] = oy;
            end
            OP_SET_SPIN: begin
                body_spin = ox;
            end
            OP_TRANSLATE: begin
                body_pos[0] = clip_word(longint'(body_pos[0]) + ox);
                body_pos[1] = clip_word(longint'(body_pos[1]) + oy);
            end
            OP_UPDATE: begin
                // Position and angle move with the velocities from before this step.
                for (int axis = 0; axis < 2; axis++) begin
                    body_pos[axis] = clip_word(body_pos[axis] +
                                               scale_by_step(body_vel[axis], dt));
                    acc = accel_of(force_total[axis], shadow_inv_mass);
                    body_vel[axis] = clip_word(body_vel[axis] + scale_by_step(acc, dt));
                end
                body_angle = clip_word(body_angle + scale_by_step(body_spin, dt));
                acc = accel_of(torque_total, shadow_inv_inertia);
                body_spin = clip_word(body_spin + scale_by_step(acc, dt));
            end
            default: begin
            end
        endcase
        s.pos_x     = body_pos[0];
        s.pos_y     = body_pos[1];
        s.vel_x     = body_vel[0];
        s.vel_y     = body_vel[1];
        s.angle     = body_angle;
        s.spin_rate = body_spin;
        s.saturated = clip_seen;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        // Printing stops after a while so a broken block cannot flood the log;
        // every mismatch is still counted.
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s = %h, expected %h",
                                      results_checked, name, got, want));
        end
    endtask

    task automatic check_result();
        t_body_state want;
        if (expected_states.size() == 0) begin
            report_mismatch("result returned with no request outstanding");
            return;
        end
        want = expected_states.pop_front();
        compare_field("pos_x",     o_m_tdata[31:0],    want.pos_x);
        compare_field("pos_y",     o_m_tdata[63:32],   want.pos_y);
        compare_field("vel_x",     o_m_tdata[95:64],   want.vel_x);
        compare_field("vel_y",     o_m_tdata[127:96],  want.vel_y);
        compare_field("angle",     o_m_tdata[159:128], want.angle);
        compare_field("spin_rate", o_m_tdata[191:160], want.spin_rate);
        compare_field("saturated", {31'd0, o_m_tdata[192]}, {31'd0, want.saturated});
        results_checked++;
    endtask

    // Outputs are sampled at the clock edge, before any update of this edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: random stall bursts, plus a long hold-off on request of a
    // test. The hold is counted down here at every clock edge.
    // ------------------------------------------------------------------------
    initial begin : output_ready_driver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_left > 0) begin
                hold_cycles_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge that accepts it. The valid
    // stays high afterward so that back-to-back requests need no toggle.
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic signed [WORD_W-1:0] ox,
                                input logic signed [WORD_W-1:0] oy,
                                input logic [15:0] dt);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - 83){1'b0}}, dt, oy, ox, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_states.insert(expected_states.size(), advance_body(op, ox, oy, dt));
        requests_sent++;
        if (op == OP_UPDATE) updates_sent++;
    endtask

    // Waits until the block has returned everything, then writes one register.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [WORD_W-1:0] value);
        i_s_tvalid <= 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        // Only the low 31 bits are kept; unmapped indexes change nothing.
        if (index == REG_INV_MASS) begin
            shadow_inv_mass = value[INV_W-1:0];
        end else if (index == REG_INV_INERTIA) begin
            shadow_inv_inertia = value[INV_W-1:0];
        end
        register_writes++;
    endtask

    task automatic set_inverses(input logic [WORD_W-1:0] inv_mass,
                                input logic [WORD_W-1:0] inv_inertia);
        write_register(REG_INV_MASS, inv_mass);
        write_register(REG_INV_INERTIA, inv_inertia);
    endtask

    // Mostly moderate values so the body keeps moving instead of sitting on a
    // rail, with rails and fully random words mixed in.
    function automatic logic signed [WORD_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return WORD_POS_MAX;
            1:       return WORD_NEG_MAX;
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
        endcase
    endfunction

    function automatic logic [15:0] random_step();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DT_MAX;
            2, 3:    return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random_requests(input int count);
        logic [OPCODE_W-1:0] op;
        repeat (count) begin
            case ($urandom_range(0, 19))
                0, 1:    op = OP_ADD_FORCE;
                2, 3:    op = OP_ADD_TORQUE;
                4, 5:    op = OP_SET_VEL;
                6, 7:    op = OP_SET_SPIN;
                8, 9:    op = OP_TRANSLATE;
                10:      op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                default: op = OP_UPDATE;
            endcase
            send_request(op, random_operand(), random_operand(), random_step());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Right after reset the body is at rest; spare opcodes must report it as is.
    task automatic test_spare_opcodes();
        send_request(OP_SPARE_LO, WORD_POS_MAX, WORD_NEG_MAX, DT_MAX);
        send_request(OP_SPARE_HI, WORD_NEG_MAX, WORD_POS_MAX, DT_MAX);
    endtask

    // Rails of every field, every opcode, clipping of each kind and the
    // rounding of negative products toward minus infinity.
    task automatic test_directed_extremes();
        send_request(OP_SET_VEL, WORD_POS_MAX, WORD_NEG_MAX, '0);
        // Operand y must not matter for a spin write.
        send_request(OP_SET_SPIN, WORD_NEG_MAX, WORD_POS_MAX, DT_MAX);
        send_request(OP_UPDATE, random_operand(), WORD_POS_MAX, DT_MAX);
        // The second full step pushes position and angle onto the rails.
        send_request(OP_UPDATE, random_operand(), random_operand(), DT_MAX);
        send_request(OP_UPDATE, random_operand(), random_operand(), '0);
        send_request(OP_TRANSLATE, WORD_NEG_MAX, WORD_POS_MAX, DT_MAX);
        send_request(OP_TRANSLATE, WORD_NEG_MAX, WORD_NEG_MAX, '0);
        send_request(OP_ADD_FORCE, WORD_POS_MAX, WORD_POS_MAX, '0);
        send_request(OP_ADD_FORCE, WORD_POS_MAX, WORD_POS_MAX, '0);
        send_request(OP_ADD_TORQUE, WORD_NEG_MAX, WORD_POS_MAX, '0);
        send_request(OP_ADD_TORQUE, WORD_NEG_MAX, random_operand(), '0);
        send_request(OP_UPDATE, random_operand(), random_operand(), 16'd1);

        // Largest inverses: the acceleration itself has to clip.
        set_inverses(INV_MAX, INV_MAX);
        send_request(OP_UPDATE, random_operand(), random_operand(), DT_MAX);

        // Zero inverses make an immovable body that also never spins up.
        set_inverses('0, '0);
        send_request(OP_SET_VEL, '0, '0, '0);
        send_request(OP_SET_SPIN, '0, random_operand(), '0);
        send_request(OP_UPDATE, random_operand(), random_operand(), DT_MAX);
        send_request(OP_ADD_FORCE, WORD_NEG_MAX, WORD_NEG_MAX, '0);
        send_request(OP_UPDATE, random_operand(), random_operand(), DT_MAX);

        // A tiny negative velocity over one step must floor to minus one.
        set_inverses(32'd65536, 32'd65536);
        send_request(OP_SET_VEL, 32'sd1, -32'sd1, '0);
        send_request(OP_SET_SPIN, -32'sd1, '0, '0);
        send_request(OP_UPDATE, '0, '0, 16'd1);
    endtask

    // Random traffic under a sweep of register settings. Bit 31 of the write
    // data must be dropped, and writes to unmapped indexes must be ignored.
    task automatic test_register_settings();
        set_inverses('0, INV_MAX);
        send_random_requests(45);

        set_inverses(INV_MAX, '0);
        send_random_requests(45);

        set_inverses(32'd1, 32'd1);
        send_random_requests(45);

        set_inverses(32'hFFFFFFFF, 32'h80010000);
        send_random_requests(45);

        write_register(UNMAPPED_IDX_LO, $urandom());
        write_register(UNMAPPED_IDX_HI, $urandom());
        set_inverses($urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h3FFFF));
        send_random_requests(45);

        // One stretch with both sides running flat out.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_inverses($urandom(), $urandom());
        send_random_requests(40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        set_inverses(32'd65536, 32'd65536);
        send_random_requests(35);
    endtask

    // The output side holds off for a long stretch while requests keep coming,
    // so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        hold_cycles_left = 300;
        tx_idle_on = 1'b0;
        send_random_requests(25);
        tx_idle_on = 1'b1;
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_requests(60);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int guard;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_spare_opcodes();
        test_directed_extremes();
        test_register_settings();
        test_output_backpressure();
        test_steady_stream();

        // Drain: every request must come back, then let the pipeline settle.
        i_s_tvalid <= 1'b0;
        guard = 0;
        while (expected_states.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_states.size() != 0) begin
            report_mismatch($sformatf("%0d results never returned", expected_states.size()));
        end
        repeat (30) @(posedge i_clk);

        $display("Run covered %0d requests (%0d updates) and %0d register writes,",
                 requests_sent, updates_sent, register_writes);
        $display("including rails, clipping, zero inverses and a long output hold; %0d %s",
                 results_checked, "results compared.");
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
